// ===== src/held_key_repeat_scheduler_assert.svh =====
// assertion macros shared by the held-key repeat scheduler rtl
`ifndef HELD_KEY_REPEAT_SCHEDULER_ASSERT_SVH
`define HELD_KEY_REPEAT_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HKRS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HKRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hkrs_pkg.sv =====
// shared constants and types for the held-key repeat scheduler
package hkrs_pkg;

  // table and time sizing
  localparam int MAX_HELD  = 16;
  localparam int SLOT_BITS = $clog2(MAX_HELD);
  localparam int TIME_BITS = 32;

  // field widths
  localparam int CMD_BITS   = 2;
  localparam int COORD_BITS = 4;
  localparam int KIND_BITS  = 2;
  localparam int IVL_BITS   = 16;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd2;

  // event codes
  localparam logic [KIND_BITS-1:0] EV_RELEASE = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_REPEAT  = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_DROPPED = 2'd2;

  // register map
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] ADDR_REPEAT_INTERVAL = 3'd0;
  localparam logic [IVL_BITS-1:0]  INTERVAL_RESET       = 16'd10;

  // one result request
  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } evt_t;

endpackage

// ===== src/hkrs_if.sv =====
// request channel interfaces for commands and reported events
interface hkrs_cmd_if import hkrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [COORD_BITS-1:0] key_x;
  logic [COORD_BITS-1:0] key_y;

  modport source (output valid, command, key_x, key_y, input ready);
  modport sink (input valid, command, key_x, key_y, output ready);
endinterface

interface hkrs_evt_if import hkrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  event_kind;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  last_of_run;

  modport source (output valid, event_kind, out_x, out_y, last_of_run, input ready);
  modport sink (input valid, event_kind, out_x, out_y, last_of_run, output ready);
endinterface

// ===== src/held_key_repeat_scheduler.sv =====
// held-key table with auto-repeat scan, one slot per cycle unless a tick scan stalls
//
//   channel | dir | fields                                    | handshake
//   cmd     | in  | command, key_x, key_y                     | valid/ready
//   evt     | out | event_kind, out_x, out_y, last_of_run     | valid/ready
//   apb     | cfg | paddr[2:0], pwdata -> repeat_interval      | psel/penable
//
// press, release and tick run accept, a scan over all 16 slots, then finish
// the slot scan walks the table through one shared compare and subtract unit
// unused command 3 is accepted and changes nothing
// a tick scan stalls on a due slot while an earlier due key waits and the output register is full
// rst is synchronous: table empty, time zero, repeat_interval back to 10
`include "held_key_repeat_scheduler_assert.svh"

module held_key_repeat_scheduler import hkrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  hkrs_cmd_if.sink             cmd,
  hkrs_evt_if.source           evt,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_HELD - 1);

  // control state
  logic [1:0]            state;
  logic [SLOT_BITS-1:0]  scan_idx;
  logic [CMD_BITS-1:0]   cmd_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;
  logic                  found;
  logic                  have_free;
  logic [SLOT_BITS-1:0]  free_idx;
  logic                  pend_valid;
  logic [COORD_BITS-1:0] pend_x;
  logic [COORD_BITS-1:0] pend_y;
  logic [TIME_BITS-1:0]  now_ticks;
  logic [IVL_BITS-1:0]   repeat_interval;

  // slot table
  logic [MAX_HELD-1:0]   slot_valid;
  logic [COORD_BITS-1:0] slot_col   [MAX_HELD];
  logic [COORD_BITS-1:0] slot_row   [MAX_HELD];
  logic [TIME_BITS-1:0]  slot_stamp [MAX_HELD];

  // output register
  logic out_valid;
  evt_t out_data;

  logic                  accept;
  logic                  out_free;
  logic                  push;
  evt_t                  push_data;
  logic                  cur_valid;
  logic                  cur_match;
  logic                  cur_due;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  stall;
  logic                  stamp_we;
  logic [SLOT_BITS-1:0]  stamp_idx;
  logic                  key_we;
  logic                  cfg_write;

  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !out_valid || evt.ready;

  // shared compare unit on the slot under scan
  assign cur_valid = slot_valid[scan_idx];
  assign cur_match = cur_valid && (slot_col[scan_idx] == x_r) && (slot_row[scan_idx] == y_r);
  assign elapsed   = now_ticks - slot_stamp[scan_idx];
  assign cur_due   = cur_valid && (elapsed >= TIME_BITS'(repeat_interval));
  assign stall     = (state == S_SCAN) && (cmd_r == CMD_TICK) && cur_due && pend_valid &&
                     !out_free;

  // result push and table write selection
  always_comb begin
    push      = 1'b0;
    push_data = '{kind: EV_REPEAT, x: pend_x, y: pend_y, last: 1'b0};
    stamp_we  = 1'b0;
    stamp_idx = scan_idx;
    key_we    = 1'b0;
    unique case (state)
      S_SCAN: begin
        if (cmd_r == CMD_TICK && cur_due && !stall) begin
          stamp_we = 1'b1;
          push     = pend_valid;
        end
      end
      S_DONE: begin
        case (cmd_r)
          CMD_PRESS: begin
            if (!found && have_free) begin
              key_we    = 1'b1;
              stamp_we  = 1'b1;
              stamp_idx = free_idx;
            end else if (!found && out_free) begin
              push      = 1'b1;
              push_data = '{kind: EV_DROPPED, x: x_r, y: y_r, last: 1'b1};
            end
          end
          CMD_RELEASE: begin
            push      = out_free;
            push_data = '{kind: EV_RELEASE, x: x_r, y: y_r, last: 1'b1};
          end
          default: begin
            push           = pend_valid && out_free;
            push_data.last = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_idx   <= '0;
      found      <= 1'b0;
      have_free  <= 1'b0;
      pend_valid <= 1'b0;
      now_ticks  <= '0;
      slot_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            found     <= 1'b0;
            have_free <= 1'b0;
            scan_idx  <= '0;
            if (cmd.command == CMD_TICK) begin
              now_ticks <= now_ticks + 1'b1;
            end
            if (cmd.command == CMD_PRESS || cmd.command == CMD_RELEASE ||
                cmd.command == CMD_TICK) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!stall) begin
            case (cmd_r)
              CMD_PRESS: begin
                if (cur_match) begin
                  found <= 1'b1;
                end
                if (!cur_valid && !have_free) begin
                  have_free <= 1'b1;
                  free_idx  <= scan_idx;
                end
              end
              CMD_RELEASE: begin
                if (cur_match) begin
                  slot_valid[scan_idx] <= 1'b0;
                end
              end
              default: begin
                if (cur_due) begin
                  pend_valid <= 1'b1;
                  pend_x     <= slot_col[scan_idx];
                  pend_y     <= slot_row[scan_idx];
                end
              end
            endcase
            if (scan_idx == LAST_SLOT) begin
              scan_idx <= '0;
              state    <= S_DONE;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          case (cmd_r)
            CMD_PRESS: begin
              if (found || have_free || out_free) begin
                state <= S_IDLE;
              end
              if (key_we) begin
                slot_valid[free_idx] <= 1'b1;
              end
            end
            CMD_RELEASE: begin
              if (out_free) begin
                state <= S_IDLE;
              end
            end
            default: begin
              if (!pend_valid || out_free) begin
                pend_valid <= 1'b0;
                state      <= S_IDLE;
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latched request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd.command;
      x_r   <= cmd.key_x;
      y_r   <= cmd.key_y;
    end
  end

  // slot payload storage
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      slot_stamp[stamp_idx] <= now_ticks;
    end
    if (key_we) begin
      slot_col[free_idx] <= x_r;
      slot_row[free_idx] <= y_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

  assign evt.valid       = out_valid;
  assign evt.event_kind  = out_data.kind;
  assign evt.out_x       = out_data.x;
  assign evt.out_y       = out_data.y;
  assign evt.last_of_run = out_data.last;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= INTERVAL_RESET;
    end else if (cfg_write && paddr[ADDR_BITS-1] == ADDR_REPEAT_INTERVAL[ADDR_BITS-1]) begin
      repeat_interval <= pwdata[IVL_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_BITS-1] == ADDR_REPEAT_INTERVAL[ADDR_BITS-1]) begin
      prdata = 32'(repeat_interval);
    end
  end

  // checks
  `HKRS_ASSERT_NEXT(a_tick_advances, accept && cmd.command == CMD_TICK,
                    now_ticks == $past(now_ticks) + 1'b1, "tick did not advance time")
  `HKRS_ASSERT_IMPL(a_idle_no_pend, state == S_IDLE, !pend_valid,
                    "pending repeat left behind at idle")
  `HKRS_ASSERT_IMPL(a_idle_idx_zero, state == S_IDLE, scan_idx == '0,
                    "scan index not rewound at idle")
  `HKRS_ASSERT_IMPL(a_push_room, push, out_free, "result pushed over a held result")

endmodule
